// ===== rtl/core/utf8_sequence_codec_defines.svh =====
// assertion macros shared by the utf8 codec rtl
`ifndef UTF8_SEQUENCE_CODEC_DEFINES_SVH
`define UTF8_SEQUENCE_CODEC_DEFINES_SVH

// same-cycle implication, checked outside reset
`define U8SC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 codec assertion failed");

// next-cycle implication, checked outside reset
`define U8SC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 codec assertion failed");

`endif

// ===== rtl/core/u8sc_pkg.sv =====
// types, widths and conversion functions for the utf8 sequence codec
package u8sc_pkg;

  localparam int unsigned PointW    = 31;
  localparam int unsigned NumBytes  = 6;
  localparam int unsigned CountW    = 3;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 88;
  localparam int unsigned InUsedW   = PointW + NumBytes * 8;
  localparam int unsigned OutUsedW  = NumBytes * 8 + CountW + PointW;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef logic [NumBytes-1:0][7:0] seq_bytes_t;

  typedef struct packed {
    logic                bad_sequence;
    logic [PointW-1:0]   decoded_point;
    logic [CountW-1:0]   seq_len;
    seq_bytes_t          out_bytes;
  } u8sc_result_t;

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    return {2'b10, bits};
  endfunction

  function automatic u8sc_result_t utf8_encode(input logic [PointW-1:0] c);
    u8sc_result_t r;
    r = '0;
    if (c <= 31'h7F) begin
      r.seq_len      = 3'd1;
      r.out_bytes[0] = {1'b0, c[6:0]};
    end else if (c <= 31'h7FF) begin
      r.seq_len      = 3'd2;
      r.out_bytes[0] = {3'b110, c[10:6]};
      r.out_bytes[1] = cont_byte(c[5:0]);
    end else if (c <= 31'hFFFF) begin
      r.seq_len      = 3'd3;
      r.out_bytes[0] = {4'b1110, c[15:12]};
      r.out_bytes[1] = cont_byte(c[11:6]);
      r.out_bytes[2] = cont_byte(c[5:0]);
    end else if (c <= 31'h1FFFFF) begin
      r.seq_len      = 3'd4;
      r.out_bytes[0] = {5'b11110, c[20:18]};
      r.out_bytes[1] = cont_byte(c[17:12]);
      r.out_bytes[2] = cont_byte(c[11:6]);
      r.out_bytes[3] = cont_byte(c[5:0]);
    end else if (c <= 31'h3FFFFFF) begin
      r.seq_len      = 3'd5;
      r.out_bytes[0] = {6'b111110, c[25:24]};
      r.out_bytes[1] = cont_byte(c[23:18]);
      r.out_bytes[2] = cont_byte(c[17:12]);
      r.out_bytes[3] = cont_byte(c[11:6]);
      r.out_bytes[4] = cont_byte(c[5:0]);
    end else begin
      r.seq_len      = 3'd6;
      r.out_bytes[0] = {7'b1111110, c[30]};
      r.out_bytes[1] = cont_byte(c[29:24]);
      r.out_bytes[2] = cont_byte(c[23:18]);
      r.out_bytes[3] = cont_byte(c[17:12]);
      r.out_bytes[4] = cont_byte(c[11:6]);
      r.out_bytes[5] = cont_byte(c[5:0]);
    end
    return r;
  endfunction

  // span of a lead byte, zero for a continuation byte or 0xfe/0xff
  function automatic logic [CountW-1:0] lead_span(input logic [7:0] b);
    logic [CountW-1:0] s;
    if (b[7] == 1'b0)               s = 3'd1;
    else if (b[7:6] == 2'b10)       s = 3'd0;
    else if (b[7:5] == 3'b110)      s = 3'd2;
    else if (b[7:4] == 4'b1110)     s = 3'd3;
    else if (b[7:3] == 5'b11110)    s = 3'd4;
    else if (b[7:2] == 6'b111110)   s = 3'd5;
    else if (b[7:1] == 7'b1111110)  s = 3'd6;
    else                            s = 3'd0;
    return s;
  endfunction

  function automatic u8sc_result_t utf8_decode(input seq_bytes_t b);
    u8sc_result_t      r;
    logic [CountW-1:0] span;
    logic              bad;
    logic [PointW-1:0] pt;
    r    = '0;
    span = lead_span(b[0]);
    bad  = (span == 3'd0);
    for (int i = 1; i < NumBytes; i++) begin
      if ((CountW'(i) < span) && (b[i][7:6] != 2'b10)) bad = 1'b1;
    end
    case (span)
      3'd1:    pt = PointW'(b[0][6:0]);
      3'd2:    pt = PointW'({b[0][4:0], b[1][5:0]});
      3'd3:    pt = PointW'({b[0][3:0], b[1][5:0], b[2][5:0]});
      3'd4:    pt = PointW'({b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]});
      3'd5:    pt = PointW'({b[0][1:0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0]});
      3'd6:    pt = {b[0][0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0], b[5][5:0]};
      default: pt = '0;
    endcase
    r.bad_sequence = bad;
    if (!bad) begin
      r.seq_len       = span;
      r.decoded_point = pt;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/utf8_sequence_codec.sv =====
// utf8 sequence codec: code point to six-byte utf8 and back, two-stage pipeline
//
// input channel s_axis: tuser carries the command (0 encode, 1 decode), tdata
// carries the code point and the six sequence bytes. output channel m_axis:
// tdata carries the six encoded bytes, the byte count and the decoded point,
// tuser carries the bad-sequence flag.
// every transaction yields exactly one result transaction, in order.
// an accepted input passes one input register, the combinational encode
// or decode, then the result register.
// throughput is one transaction per cycle while the receiver does not stall; the
// conversion is a single pass of compares and bit slicing with no kept state.
// reset clears both stage valid bits; no result is pending after reset.
// when the receiver stalls the result register holds, the input register
// fills behind it, and s_axis_tready drops only once both stages are full.
`include "utf8_sequence_codec_defines.svh"

module utf8_sequence_codec
  import u8sc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // code_point[30:0], in_byte0..in_byte5 [78:31], zero pad [79]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_byte0..out_byte5 [47:0], seq_len [50:48], decoded_point [81:51], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // bad_sequence
  output logic                m_axis_tuser
);

  logic              in_valid;
  cmd_t              in_cmd;
  logic [PointW-1:0] in_code_point;
  seq_bytes_t        in_bytes;

  logic              out_valid;
  u8sc_result_t      out_result;
  u8sc_result_t      result_next;

  logic              out_advance;
  logic              in_advance;

  assign out_advance   = !out_valid || m_axis_tready;
  assign in_advance    = !in_valid || out_advance;
  assign s_axis_tready = in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_advance) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && s_axis_tvalid) begin
      in_cmd        <= cmd_t'(s_axis_tuser);
      in_code_point <= s_axis_tdata[PointW-1:0];
      in_bytes      <= s_axis_tdata[InUsedW-1:PointW];
    end
  end

  always_comb begin
    case (in_cmd)
      CMD_ENCODE: result_next = utf8_encode(in_code_point);
      CMD_DECODE: result_next = utf8_decode(in_bytes);
      default:    result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      out_result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_result.bad_sequence;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_result.decoded_point,
                          out_result.seq_len, out_result.out_bytes};

  // an error result carries no count, no point and no bytes
  `U8SC_ASSERT_NOW(a_bad_is_empty, out_valid && out_result.bad_sequence,
    out_result.seq_len == 3'd0 && out_result.decoded_point == '0 &&
    out_result.out_bytes == '0)
  // a good result always has a length of one to six
  `U8SC_ASSERT_NOW(a_count_range, out_valid && !out_result.bad_sequence,
    out_result.seq_len != 3'd0 && out_result.seq_len <= 3'd6)
  // encode and decode fields never mix in one result
  `U8SC_ASSERT_NOW(a_no_mixed, out_valid && out_result.decoded_point != '0,
    out_result.out_bytes == '0)
  // a full input stage with a stalled output never takes a new transaction
  `U8SC_ASSERT_NOW(a_no_overrun, in_valid && out_valid && !m_axis_tready,
    !s_axis_tready)
  // a stalled result with a full input stage keeps the input stage full
  `U8SC_ASSERT_NEXT(a_hold_input, in_valid && out_valid && !m_axis_tready,
    in_valid && out_valid)

endmodule
